@@ design/mpf_pkg.sv @@
// Shared types and constants for the mini printf formatter.
package mpf_pkg;

    localparam int NUM_SLOTS = 5;   // most results one item can cause
    localparam int CNT_W     = 3;   // result count 0..5
    localparam int IDX_W     = 3;   // index into the result slots
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        OP_FORMAT = 2'd0,
        OP_STRING = 2'd1,
        OP_END    = 2'd2
    } opcode_t;

    localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
    localparam logic [7:0] CH_QUEST   = 8'h3F;  // '?'
    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOWER_D = 8'h64;  // 'd'
    localparam logic [7:0] CH_UPPER_D = 8'h44;  // 'D'
    localparam logic [7:0] CH_LOWER_X = 8'h78;  // 'x'
    localparam logic [7:0] CH_UPPER_X = 8'h58;  // 'X'
    localparam logic [7:0] CH_LOWER_C = 8'h63;  // 'c'
    localparam logic [7:0] CH_LOWER_S = 8'h73;  // 's'
    localparam logic [7:0] CH_UPPER_S = 8'h53;  // 'S'

    // quotients of the decimal value by 10, 100, 1000 and 10000
    typedef struct packed {
        logic [12:0] q1;
        logic [9:0]  q2;
        logic [6:0]  q3;
        logic [2:0]  q4;
    } dec_quot_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  ch;
        logic [15:0] arg;
        logic [15:0] dec_val;
        dec_quot_t   quot;
    } item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [6:0] pos;
        logic       done;
        logic [6:0] len;
    } slot_t;

    typedef struct packed {
        slot_t [NUM_SLOTS-1:0] slots;
        logic  [CNT_W-1:0]     cnt;
    } res_list_t;

endpackage

@@ design/mini_printf_formatter.sv @@
// An accepted item is held in the input register and decoded; its results are
//   then loaded into the result buffer, which drives the master side. An item
//   with no result only updates the state. The one-character-per-cycle result
//   port sets the rate while m_tready is high; the next item is decoded while results drain.
// Reset: rst_n clears write position, pending percent and all valid flags.
// Top level of the mini printf formatter.
module mini_printf_formatter #(
    parameter int BUFFER_DEPTH = 128
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side: input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mpf_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] char_in, [23:8] argument
    input  logic [mpf_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] opcode
    // master side: result characters
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mpf_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] char_out, [14:8] position,
                                                     // [21:15] message_length, [23:22] zero
    output logic                          m_tuser,   // [0] is_done
    output logic                          m_tlast    // final result of this item
);

    localparam int PW = $clog2(BUFFER_DEPTH);

    // input register stage
    logic               in_valid_reg;
    logic               in_valid_next;
    mpf_pkg::item_t     item_reg;
    mpf_pkg::item_t     item_next;
    mpf_pkg::item_t     cap_item;
    mpf_pkg::dec_quot_t cap_quot;
    logic [15:0]        cap_dec;
    logic               s_xfer;

    // message state
    logic [PW-1:0]      wp_reg;
    logic [PW-1:0]      wp_next;
    logic               pct_reg;
    logic               pct_next;
    logic [PW-1:0]      dec_wp;
    logic               dec_pct;

    mpf_pkg::res_list_t list;
    logic               buf_load;
    logic               buf_free;
    mpf_pkg::slot_t     out_slot;
    logic               advance;

    assign s_xfer = s_tvalid && s_tready;

    // Decimal value is picked at capture ('d' uses the low byte only), so the
    // reciprocal multiplies sit before the input register.
    assign cap_dec = (s_tdata[7:0] == mpf_pkg::CH_LOWER_D) ?
                     {8'h00, s_tdata[15:8]} : s_tdata[23:8];

    always_comb
    begin
        cap_item.opcode  = mpf_pkg::opcode_t'(s_tuser);
        cap_item.ch      = s_tdata[7:0];
        cap_item.arg     = s_tdata[23:8];
        cap_item.dec_val = cap_dec;
        cap_item.quot    = cap_quot;
    end

    mpf_dec_split u_split
    (
        .value (cap_dec),
        .quot  (cap_quot)
    );

    mpf_decode #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_decode
    (
        .item     (item_reg),
        .wp       (wp_reg),
        .pct      (pct_reg),
        .list     (list),
        .wp_next  (dec_wp),
        .pct_next (dec_pct)
    );

    // The registered item moves on when its results fit into the buffer;
    // an item without results just updates the state.
    assign advance  = in_valid_reg && ((list.cnt == '0) || buf_free);
    assign buf_load = advance && (list.cnt != '0);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
            item_next     = cap_item;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        wp_next  = advance ? dec_wp : wp_reg;
        pct_next = advance ? dec_pct : pct_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            wp_reg       <= '0;
            pct_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            wp_reg       <= wp_next;
            pct_reg      <= pct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    mpf_out_buf u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .list     (list),
        .load     (buf_load),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .slot     (out_slot),
        .last     (m_tlast)
    );

    assign m_tdata = {2'b00, out_slot.len, out_slot.pos, out_slot.ch};
    assign m_tuser = out_slot.done;

endmodule

@@ design/mpf_dec_split.sv @@
// Reciprocal multiplies giving the decimal quotients of a 16-bit value.
module mpf_dec_split
(
    input  logic [15:0]        value,
    output mpf_pkg::dec_quot_t quot
);

    // m = ceil(2^k / d); exact for every 16-bit value
    localparam logic [32:0] M10    = 33'd52429;   // k = 19
    localparam logic [32:0] M100   = 33'd83887;   // k = 23
    localparam logic [32:0] M1000  = 33'd67109;   // k = 26
    localparam logic [32:0] M10000 = 33'd107375;  // k = 30

    logic [32:0] prod1;
    logic [32:0] prod2;
    logic [32:0] prod3;
    logic [32:0] prod4;

    assign prod1 = 33'(value) * M10;
    assign prod2 = 33'(value) * M100;
    assign prod3 = 33'(value) * M1000;
    assign prod4 = 33'(value) * M10000;

    assign quot.q1 = prod1[31:19];
    assign quot.q2 = prod2[32:23];
    assign quot.q3 = prod3[32:26];
    assign quot.q4 = prod4[32:30];

endmodule

@@ design/mpf_decode.sv @@
// Decode of one registered item into its list of result characters.
module mpf_decode #(
    parameter int BUFFER_DEPTH = 128
)
(
    input  mpf_pkg::item_t               item,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] wp,
    input  logic                         pct,
    output mpf_pkg::res_list_t           list,
    output logic [$clog2(BUFFER_DEPTH)-1:0] wp_next,
    output logic                         pct_next
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int SW = PW + mpf_pkg::CNT_W + 1;
    localparam int XW = (PW > 7) ? PW : 7;
    localparam logic [SW-1:0] LAST_SLOT = SW'(BUFFER_DEPTH - 1);

    logic [7:0]               raw [mpf_pkg::NUM_SLOTS];
    logic [mpf_pkg::CNT_W-1:0] rcnt;
    logic [mpf_pkg::CNT_W-1:0] nch;
    logic                     done;
    logic [3:0]               dig [mpf_pkg::NUM_SLOTS];
    logic [mpf_pkg::IDX_W-1:0] top;
    logic [mpf_pkg::IDX_W-1:0] sel;

    function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] base,
                                              input logic [mpf_pkg::CNT_W-1:0] k);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(k);
        if (s >= LAST_SLOT)
        begin
            return LAST_SLOT[PW-1:0];
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [6:0] to7(input logic [PW-1:0] v);
        logic [XW-1:0] e;
        e = XW'(v);
        return e[6:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return mpf_pkg::CH_ZERO + {4'h0, n};
        end
        return mpf_pkg::CH_LOWER_A + {4'h0, n} - 8'd10;
    endfunction

    // decimal digits from the quotients: d_k = q_k - 10 * q_(k+1)
    always_comb
    begin
        dig[0] = 4'(item.dec_val - {item.quot.q1, 3'b000} - 16'({item.quot.q1, 1'b0}));
        dig[1] = 4'(item.quot.q1 - {item.quot.q2, 3'b000} - 13'({item.quot.q2, 1'b0}));
        dig[2] = 4'(item.quot.q2 - {item.quot.q3, 3'b000} - 10'({item.quot.q3, 1'b0}));
        dig[3] = 4'(item.quot.q3 - {item.quot.q4, 3'b000} - 7'({item.quot.q4, 1'b0}));
        dig[4] = {1'b0, item.quot.q4};
        if (item.quot.q4 != '0)
            top = 3'd4;
        else if (item.quot.q3 != '0)
            top = 3'd3;
        else if (item.quot.q2 != '0)
            top = 3'd2;
        else if (item.quot.q1 != '0)
            top = 3'd1;
        else
            top = 3'd0;
    end

    always_comb
    begin
        for (int i = 0; i < mpf_pkg::NUM_SLOTS; i++)
        begin
            raw[i] = 8'h00;
        end
        rcnt     = '0;
        done     = 1'b0;
        sel      = '0;
        pct_next = pct;

        unique case (item.opcode)
            mpf_pkg::OP_FORMAT:
            begin
                if (!pct)
                begin
                    if (item.ch == mpf_pkg::CH_PERCENT)
                    begin
                        pct_next = 1'b1;
                    end
                    else
                    begin
                        raw[0] = item.ch;
                        rcnt   = 3'd1;
                    end
                end
                else
                begin
                    pct_next = 1'b0;
                    unique case (item.ch)
                        mpf_pkg::CH_LOWER_D, mpf_pkg::CH_UPPER_D:
                        begin
                            for (int i = 0; i < mpf_pkg::NUM_SLOTS; i++)
                            begin
                                if (3'(i) <= top)
                                begin
                                    sel    = top - 3'(i);
                                    raw[i] = mpf_pkg::CH_ZERO | {4'h0, dig[sel]};
                                end
                            end
                            rcnt = top + 3'd1;
                        end
                        mpf_pkg::CH_LOWER_X:
                        begin
                            raw[0] = hex_char(item.arg[7:4]);
                            raw[1] = hex_char(item.arg[3:0]);
                            rcnt   = 3'd2;
                        end
                        mpf_pkg::CH_UPPER_X:
                        begin
                            raw[0] = hex_char(item.arg[15:12]);
                            raw[1] = hex_char(item.arg[11:8]);
                            raw[2] = hex_char(item.arg[7:4]);
                            raw[3] = hex_char(item.arg[3:0]);
                            rcnt   = 3'd4;
                        end
                        mpf_pkg::CH_LOWER_C:
                        begin
                            raw[0] = item.arg[7:0];
                            rcnt   = 3'd1;
                        end
                        mpf_pkg::CH_LOWER_S, mpf_pkg::CH_UPPER_S:
                        begin
                            rcnt = '0;
                        end
                        mpf_pkg::CH_PERCENT:
                        begin
                            raw[0] = mpf_pkg::CH_PERCENT;
                            rcnt   = 3'd1;
                        end
                        default:
                        begin
                            raw[0] = item.ch;
                            raw[1] = mpf_pkg::CH_QUEST;
                            rcnt   = 3'd2;
                        end
                    endcase
                end
            end
            mpf_pkg::OP_STRING:
            begin
                raw[0] = item.ch;
                rcnt   = 3'd1;
            end
            mpf_pkg::OP_END:
            begin
                if (pct)
                begin
                    raw[0] = mpf_pkg::CH_QUEST;
                    rcnt   = 3'd1;
                end
                done     = 1'b1;
                pct_next = 1'b0;
            end
            default:
            begin
                rcnt = '0;
            end
        endcase

        // only the first character can be a zero byte; drop it
        nch = rcnt;
        if (rcnt != '0 && raw[0] == 8'h00)
        begin
            for (int i = 0; i < mpf_pkg::NUM_SLOTS - 1; i++)
            begin
                raw[i] = raw[i+1];
            end
            raw[mpf_pkg::NUM_SLOTS-1] = 8'h00;
            nch = rcnt - 3'd1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < mpf_pkg::NUM_SLOTS; i++)
        begin
            list.slots[i] = '0;
            if (3'(i) < nch)
            begin
                list.slots[i].ch  = raw[i];
                list.slots[i].pos = to7(sat_add(wp, 3'(i)));
            end
            else if (3'(i) == nch && done)
            begin
                list.slots[i].done = 1'b1;
                list.slots[i].len  = to7(sat_add(wp, nch));
            end
        end
        list.cnt = nch + {2'b00, done};
        wp_next  = done ? '0 : sat_add(wp, nch);
    end

endmodule

@@ design/mpf_out_buf.sv @@
// Result buffer that hands out one character transaction per cycle while m_tready is high.
module mpf_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mpf_pkg::res_list_t   list,
    input  logic                 load,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output mpf_pkg::slot_t       slot,
    output logic                 last
);

    logic                                   valid_reg;
    logic                                   valid_next;
    logic [mpf_pkg::CNT_W-1:0]              cnt_reg;
    logic [mpf_pkg::CNT_W-1:0]              cnt_next;
    logic [mpf_pkg::IDX_W-1:0]              idx_reg;
    logic [mpf_pkg::IDX_W-1:0]              idx_next;
    mpf_pkg::slot_t [mpf_pkg::NUM_SLOTS-1:0] slots_reg;
    mpf_pkg::slot_t [mpf_pkg::NUM_SLOTS-1:0] slots_next;

    assign last     = (idx_reg == (cnt_reg - 3'd1));
    assign free     = !valid_reg || (m_tready && last);
    assign m_tvalid = valid_reg;
    assign slot     = slots_reg[idx_reg];

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        slots_next = slots_reg;
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = list.cnt;
            idx_next   = '0;
            slots_next = list.slots;
        end
        else if (valid_reg && m_tready)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
    end

endmodule

@@ design/mpf_checker.sv @@
// Port-level checks for the mini printf formatter, bound to the top level.
module mpf_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mpf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // end report: no character, slot 0, always closes its item
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[14:0] == 15'h0000 && m_tlast)
        else $error("malformed end report");

    // character result: nonzero byte, no length
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[7:0] != 8'h00 && m_tdata[21:15] == 7'h00)
        else $error("malformed character result");

    // the rest of an item's results are already buffered
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an item's results");

endmodule

bind mini_printf_formatter mpf_checker u_mpf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
